// File: rtl/core/gbte_pkg.sv
// gap buffer text engine: shared constants, operation and status codes, and the
// structs passed between the controller, the text memory and the top level.
// no dependencies.
package gbte_pkg;

   localparam int CAPACITY = 4096;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int POS_W    = 13;
   localparam int CHAR_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STAT_W   = 2;

   localparam logic [POS_W-1:0]  CAP_POS = POS_W'(CAPACITY);
   localparam logic [CHAR_W-1:0] NEWLINE = CHAR_W'(10);

   localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DEL_BEFORE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DEL_AFTER  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ       = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LINE_START = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LINE_END   = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic              valid;
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [CHAR_W-1:0] char_out;
      logic [POS_W-1:0]  text_length;
   } result_type;

endpackage

// File: rtl/core/gbte_text_ram.sv
// gap buffer text engine: character store, one write port and one read port,
// read data registered. uses gbte_pkg.
module gbte_text_ram (
   input  logic                          clock,
   input  gbte_pkg::mem_req_type         mem_req,
   output logic [gbte_pkg::CHAR_W-1:0]   rd_data
);

   logic [gbte_pkg::CHAR_W-1:0] mem_array [gbte_pkg::CAPACITY];
   logic [gbte_pkg::CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_array[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_array[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/gbte_ctrl.sv
// gap buffer text engine: operation sequencer. holds the gap pointers, moves
// the gap one character a cycle through the text memory and runs line scans.
// uses gbte_pkg; drives gbte_text_ram.
module gbte_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gbte_pkg::KIND_W-1:0]   req_kind,
   input  logic [gbte_pkg::POS_W-1:0]    req_cursor,
   input  logic [gbte_pkg::CHAR_W-1:0]   req_char_in,
   output gbte_pkg::mem_req_type         mem_req,
   input  logic [gbte_pkg::CHAR_W-1:0]   rd_data,
   output gbte_pkg::result_type          result,
   input  logic                          result_take
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MOVE  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   localparam int AW = gbte_pkg::ADDR_W;
   localparam int PW = gbte_pkg::POS_W;
   localparam int CW = gbte_pkg::CHAR_W;
   localparam int SW = gbte_pkg::STAT_W;

   logic [2:0]    state_ff, state_in;
   logic [gbte_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [PW-1:0] cur_ff, cur_in;
   logic [CW-1:0] ins_data_ff, ins_data_in;
   logic [PW-1:0] gap_first_ff, gap_first_in;
   logic [PW-1:0] gap_after_ff, gap_after_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [PW-1:0] scan_pos_ff, scan_pos_in;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic          scan_up_ff, scan_up_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [PW-1:0] chk_tag_ff, chk_tag_in;
   logic [SW-1:0] res_status_ff, res_status_in;
   logic [PW-1:0] res_pos_ff, res_pos_in;
   logic [CW-1:0] res_char_ff, res_char_in;

   logic [PW-1:0] text_len;
   logic          scan_more;
   logic          scan_hit;

   assign text_len  = gbte_pkg::CAP_POS - (gap_after_ff - gap_first_ff);
   assign scan_more = scan_up_ff ? (scan_pos_ff != text_len) : (scan_pos_ff != '0);
   assign scan_hit  = chk_vld_ff && (rd_data == gbte_pkg::NEWLINE);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      cur_in        = cur_ff;
      ins_data_in   = ins_data_ff;
      gap_first_in  = gap_first_ff;
      gap_after_in  = gap_after_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      scan_pos_in   = scan_pos_ff;
      scan_addr_in  = scan_addr_ff;
      scan_up_in    = scan_up_ff;
      chk_vld_in    = 1'b0;
      chk_tag_in    = chk_tag_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_char_in   = res_char_ff;
      // pending gap-move write takes the word read in the previous cycle
      mem_req.wr_en   = wr_pend_ff;
      mem_req.wr_addr = wr_addr_ff;
      mem_req.wr_data = rd_data;
      mem_req.rd_addr = scan_addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in       = req_kind;
               cur_in        = req_cursor;
               ins_data_in   = req_char_in;
               res_status_in = gbte_pkg::STAT_OK;
               res_pos_in    = req_cursor;
               res_char_in   = '0;
               state_in      = S_RESP;
               if (req_cursor > text_len) begin
                  res_status_in = gbte_pkg::STAT_RANGE;
               end else begin
                  case (req_kind) inside
                     gbte_pkg::KIND_INSERT: begin
                        if (text_len == gbte_pkg::CAP_POS) begin
                           res_status_in = gbte_pkg::STAT_FULL;
                        end else begin
                           state_in = S_MOVE;
                        end
                     end
                     gbte_pkg::KIND_DEL_BEFORE: begin
                        if (req_cursor == '0) begin
                           res_status_in = gbte_pkg::STAT_EMPTY;
                        end else begin
                           state_in = S_MOVE;
                        end
                     end
                     gbte_pkg::KIND_DEL_AFTER: begin
                        if (req_cursor == text_len) begin
                           res_status_in = gbte_pkg::STAT_EMPTY;
                        end else begin
                           state_in = S_MOVE;
                        end
                     end
                     gbte_pkg::KIND_READ, gbte_pkg::KIND_LINE_START,
                     gbte_pkg::KIND_LINE_END: begin
                        state_in = S_MOVE;
                     end
                     default: begin
                        state_in = S_RESP;
                     end
                  endcase
               end
            end
         end

         S_MOVE: begin
            if (cur_ff < gap_first_ff) begin
               // shift one word from before the gap to its far end
               mem_req.rd_addr = AW'(gap_first_ff - PW'(1));
               wr_addr_in      = AW'(gap_after_ff - PW'(1));
               wr_pend_in      = 1'b1;
               gap_first_in    = gap_first_ff - PW'(1);
               gap_after_in    = gap_after_ff - PW'(1);
            end else if (cur_ff > gap_first_ff) begin
               mem_req.rd_addr = gap_after_ff[AW-1:0];
               wr_addr_in      = gap_first_ff[AW-1:0];
               wr_pend_in      = 1'b1;
               gap_first_in    = gap_first_ff + PW'(1);
               gap_after_in    = gap_after_ff + PW'(1);
            end else if (!wr_pend_ff) begin
               // gap in place and last write drained
               case (kind_ff)
                  gbte_pkg::KIND_INSERT: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = gap_first_ff[AW-1:0];
                     mem_req.wr_data = ins_data_ff;
                     gap_first_in    = gap_first_ff + PW'(1);
                     res_pos_in      = cur_ff + PW'(1);
                     state_in        = S_RESP;
                  end
                  gbte_pkg::KIND_DEL_BEFORE: begin
                     gap_first_in = gap_first_ff - PW'(1);
                     res_pos_in   = cur_ff - PW'(1);
                     state_in     = S_RESP;
                  end
                  gbte_pkg::KIND_DEL_AFTER: begin
                     mem_req.rd_addr = gap_after_ff[AW-1:0];
                     state_in        = S_FETCH;
                  end
                  gbte_pkg::KIND_READ: begin
                     mem_req.rd_addr = gap_after_ff[AW-1:0];
                     state_in        = (cur_ff == text_len) ? S_RESP : S_FETCH;
                  end
                  gbte_pkg::KIND_LINE_START: begin
                     scan_up_in   = 1'b0;
                     scan_pos_in  = cur_ff;
                     scan_addr_in = AW'(cur_ff - PW'(1));
                     state_in     = S_SCAN;
                  end
                  gbte_pkg::KIND_LINE_END: begin
                     scan_up_in   = 1'b1;
                     scan_pos_in  = cur_ff;
                     scan_addr_in = gap_after_ff[AW-1:0];
                     state_in     = S_SCAN;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_FETCH: begin
            res_char_in = rd_data;
            if (kind_ff == gbte_pkg::KIND_DEL_AFTER) begin
               gap_after_in = gap_after_ff + PW'(1);
            end
            state_in = S_RESP;
         end

         S_SCAN: begin
            // one read issued and one word checked per cycle
            if (scan_hit) begin
               res_pos_in = chk_tag_ff;
               state_in   = S_RESP;
            end else if (!scan_more && !chk_vld_ff) begin
               res_pos_in = scan_up_ff ? text_len : '0;
               state_in   = S_RESP;
            end else if (scan_more) begin
               mem_req.rd_addr = scan_addr_ff;
               chk_vld_in      = 1'b1;
               chk_tag_in      = scan_pos_ff;
               if (scan_up_ff) begin
                  scan_pos_in  = scan_pos_ff + PW'(1);
                  scan_addr_in = scan_addr_ff + AW'(1);
               end else begin
                  scan_pos_in  = scan_pos_ff - PW'(1);
                  scan_addr_in = scan_addr_ff - AW'(1);
               end
            end
         end

         S_RESP: begin
            if (result_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gap_first_ff <= '0;
         gap_after_ff <= gbte_pkg::CAP_POS;
         wr_pend_ff   <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gap_first_ff <= gap_first_in;
         gap_after_ff <= gap_after_in;
         wr_pend_ff   <= wr_pend_in;
         chk_vld_ff   <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      cur_ff        <= cur_in;
      ins_data_ff   <= ins_data_in;
      wr_addr_ff    <= wr_addr_in;
      scan_pos_ff   <= scan_pos_in;
      scan_addr_ff  <= scan_addr_in;
      scan_up_ff    <= scan_up_in;
      chk_tag_ff    <= chk_tag_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_char_ff   <= res_char_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign result.valid       = (state_ff == S_RESP);
   assign result.status      = res_status_ff;
   assign result.position    = res_pos_ff;
   assign result.char_out    = res_char_ff;
   assign result.text_length = text_len;

   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      gap_first_ff <= gap_after_ff)
      else $error("gap start beyond gap end");

   a_gap_bound: assert property (@(posedge clock) disable iff (reset)
      gap_after_ff <= gbte_pkg::CAP_POS)
      else $error("gap end beyond capacity");

   a_wr_from_move: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> $past(state_ff) == S_MOVE)
      else $error("pending write outside gap move");

   a_scan_gap_still: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |=> $stable(gap_first_ff) && $stable(gap_after_ff))
      else $error("gap moved during line scan");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> !mem_req.wr_en)
      else $error("memory write during line scan");

endmodule

// File: rtl/core/gap_buffer_text_engine_unit.sv
// gap buffer text engine top level: controller, text memory and the result
// output register. uses gbte_pkg, gbte_text_ram and gbte_ctrl.
//
// Usage: one request word (kind, cursor, char_in) on the req_ channel gives
// exactly one response word (status, position, char_out, text_length) on the
// rsp_ channel; both channels are valid/ready. Requests are handled one at a
// time: req_ready is high only while the sequencer is idle.
// A rejected or no-op request goes straight to its response; otherwise the
// gap is first walked to the cursor at one character per cycle through the
// single read and single write port of the text memory, then its last write
// drains when the gap moved and a character is fetched for a read or a
// delete after; line start and line end scans inspect the text character by
// character until a newline or either end of the text is found.
// Reset clears the gap pointers so the text is empty; the memory itself is
// not cleared and needs no clearing pass.
// The response sits in an output register: while the receiver stalls, the
// next request is still accepted and worked on, and its result waits in the
// sequencer until the output register is free.
module gap_buffer_text_engine_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gbte_pkg::KIND_W-1:0]   req_kind,
   input  logic [gbte_pkg::POS_W-1:0]    req_cursor,
   input  logic [gbte_pkg::CHAR_W-1:0]   req_char_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gbte_pkg::STAT_W-1:0]   rsp_status,
   output logic [gbte_pkg::POS_W-1:0]    rsp_position,
   output logic [gbte_pkg::CHAR_W-1:0]   rsp_char_out,
   output logic [gbte_pkg::POS_W-1:0]    rsp_text_length
);

   gbte_pkg::mem_req_type       mem_req;
   gbte_pkg::result_type        result;
   logic [gbte_pkg::CHAR_W-1:0] rd_data;
   logic                        result_take;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gbte_pkg::STAT_W-1:0] rsp_status_ff;
   logic [gbte_pkg::POS_W-1:0]  rsp_position_ff;
   logic [gbte_pkg::CHAR_W-1:0] rsp_char_out_ff;
   logic [gbte_pkg::POS_W-1:0]  rsp_text_length_ff;

   gbte_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_cursor  (req_cursor),
      .req_char_in (req_char_in),
      .mem_req     (mem_req),
      .rd_data     (rd_data),
      .result      (result),
      .result_take (result_take)
   );

   gbte_text_ram u_text_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // output slot free when empty or being taken this cycle
   assign result_take = result.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_take) begin
         rsp_status_ff      <= result.status;
         rsp_position_ff    <= result.position;
         rsp_char_out_ff    <= result.char_out;
         rsp_text_length_ff <= result.text_length;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_char_out    = rsp_char_out_ff;
   assign rsp_text_length = rsp_text_length_ff;

endmodule
